[rtl/tksel_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and ranking function of the top-k score selector.
// No dependencies; used by tksel_cell, top_k_score_selector_core, tksel_checker and tb.
package tksel_pkg;

  localparam int unsigned CapacityK = 16;
  localparam int unsigned CntW      = $clog2(CapacityK + 1);
  localparam int unsigned LimW      = 7;
  localparam int unsigned ScoreW    = 32;
  localparam int unsigned IdxW      = 32;

  localparam logic REQ_OFFER = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  typedef struct packed {
    logic [ScoreW-1:0] score;
    logic [IdxW-1:0]   index;
  } entry_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_SHIFT
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e cmd;
    entry_t    newbie;
  } cell_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_FLUSH
  } state_e;

  // a ranks ahead of b: higher score, or equal score and lower index
  function automatic logic ranks_ahead(entry_t a, entry_t b);
    ranks_ahead = (a.score > b.score) || ((a.score == b.score) && (a.index < b.index));
  endfunction

endpackage

[rtl/tksel_cell.sv]
`timescale 1ns / 1ps
// One slot of the sorted entry chain: holds a score/index pair, inserts
// the broadcast newcomer or takes a neighbor's entry. Depends on tksel_pkg.
module tksel_cell (
  input  logic                clk_i,
  input  tksel_pkg::cell_ctrl_t ctrl_i,
  input  logic                occ_i,
  input  logic                left_ins_i,
  input  tksel_pkg::entry_t   left_i,
  input  tksel_pkg::entry_t   right_i,
  output tksel_pkg::entry_t   entry_o,
  output logic                ins_o,
  output logic                gt_o
);
  import tksel_pkg::*;

  entry_t entry_q, entry_d;

  // newcomer belongs at or before this slot
  assign ins_o   = !occ_i || ranks_ahead(ctrl_i.newbie, entry_q);
  assign gt_o    = ctrl_i.newbie.score > entry_q.score;
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.cmd)
      CMD_INSERT: begin
        // first slot that yields takes the newcomer, the rest take from the left
        if (ins_o) begin
          entry_d = left_ins_i ? left_i : ctrl_i.newbie;
        end
      end
      CMD_SHIFT: begin
        entry_d = right_i;
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

[rtl/top_k_score_selector_core.sv]
`timescale 1ns / 1ps
// Top-k score selector: keeps the best-ranked candidates of a scored stream.
// Depends on tksel_pkg and tksel_cell.
//
// Usage:
//   Command channel: an item is taken at a clock edge with start high and
//   busy low. An offer (req_type_i = 0) with a nonzero score is ranked into
//   a chain of CapacityK cells (at the limit, only if above the last entry's score);
//   the whole chain compares against the newcomer in parallel and shifts
//   right behind the insertion point. Offers give no result and busy stays
//   low, so one offer a cycle. A flush (req_type_i = 1) raises busy and
//   shifts the chain left one cell a cycle, one result beat per held entry,
//   best first, the final beat with out_last_o set. Each beat is registered
//   from the head cell in the flush state; busy stays high until the last
//   held entry is shifted out. An empty store gives one beat, out_valid_o
//   low and out_last_o high, in the cycle after the flush. Results are
//   shown for one cycle under out_strobe_o; the receiver cannot stall them.
//   Configuration: cfg_valid_i/cfg_ready_o write result_limit (0 = capacity)
//   and should be used only while the block is idle.
//   Reset empties the store, clears the limit and drops any flush in flight.
module top_k_score_selector_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic                       req_type_i,
  input  logic [tksel_pkg::ScoreW-1:0] cand_score_i,
  input  logic [tksel_pkg::IdxW-1:0]   cand_index_i,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [tksel_pkg::LimW-1:0]   cfg_result_limit_i,
  output logic                       out_strobe_o,
  output logic                       out_valid_o,
  output logic [tksel_pkg::IdxW-1:0]   out_index_o,
  output logic [tksel_pkg::ScoreW-1:0] out_score_o,
  output logic                       out_last_o
);
  import tksel_pkg::*;

  state_e           state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [LimW-1:0]  lim_q;
  logic [LimW-1:0]  eff_lim;
  logic [CntW-1:0]  occ_cnt;
  logic             offer_go, flush_go, below_lim, last_gt;

  cell_ctrl_t       ctrl;
  entry_t           cell_entry [CapacityK];
  entry_t           left_e     [CapacityK];
  entry_t           right_e    [CapacityK];
  logic [CapacityK-1:0] ins, gt, occ, left_ins, is_last;

  logic             strobe_q, strobe_d;
  logic             valid_q, valid_d, last_q, last_d;
  entry_t           res_q, res_d;

  assign busy        = (state_q == ST_FLUSH);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      lim_q <= cfg_result_limit_i;
    end
  end

  always_comb begin
    if (lim_q == '0 || lim_q > LimW'(CapacityK)) begin
      eff_lim = LimW'(CapacityK);
    end else begin
      eff_lim = lim_q;
    end
  end

  assign below_lim = LimW'(cnt_q) < eff_lim;
  assign last_gt   = |(gt & is_last);
  assign offer_go  = start && !busy && (req_type_i == REQ_OFFER) && (cand_score_i != '0) &&
                     (below_lim || ((cnt_q != '0) && last_gt));
  assign flush_go  = start && !busy && (req_type_i == REQ_FLUSH);
  // when full, the lowest entry is treated as gone before the insert
  assign occ_cnt   = below_lim ? cnt_q : cnt_q - CntW'(1);

  genvar gi;
  generate
    for (gi = 0; gi < CapacityK; gi++) begin : g_cell
      assign occ[gi]     = CntW'(gi) < occ_cnt;
      assign is_last[gi] = (CntW'(gi + 1) == cnt_q);
      if (gi == 0) begin : g_head
        assign left_ins[gi] = 1'b0;
        assign left_e[gi]   = '0;
      end else begin : g_mid
        assign left_ins[gi] = ins[gi-1];
        assign left_e[gi]   = cell_entry[gi-1];
      end
      if (gi == CapacityK - 1) begin : g_tail
        assign right_e[gi] = '0;
      end else begin : g_body
        assign right_e[gi] = cell_entry[gi+1];
      end
      tksel_cell u_cell (
        .clk_i      (clk_i),
        .ctrl_i     (ctrl),
        .occ_i      (occ[gi]),
        .left_ins_i (left_ins[gi]),
        .left_i     (left_e[gi]),
        .right_i    (right_e[gi]),
        .entry_o    (cell_entry[gi]),
        .ins_o      (ins[gi]),
        .gt_o       (gt[gi])
      );
    end
  endgenerate

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    ctrl.cmd     = CMD_HOLD;
    ctrl.newbie  = '{score: cand_score_i, index: cand_index_i};
    strobe_d     = 1'b0;
    valid_d      = 1'b0;
    last_d       = 1'b0;
    res_d        = res_q;
    case (state_q)
      ST_IDLE: begin
        if (offer_go) begin
          ctrl.cmd = CMD_INSERT;
          if (below_lim) begin
            cnt_d = cnt_q + CntW'(1);
          end
        end else if (flush_go) begin
          if (cnt_q == '0) begin
            strobe_d = 1'b1;
            last_d   = 1'b1;
            res_d    = '0;
          end else begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        // emit the head beat and advance the chain
        ctrl.cmd = CMD_SHIFT;
        strobe_d = 1'b1;
        valid_d  = 1'b1;
        res_d    = cell_entry[0];
        last_d   = (cnt_q == CntW'(1));
        cnt_d    = cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    valid_q <= valid_d;
    last_q  <= last_d;
    res_q   <= res_d;
  end

  assign out_strobe_o = strobe_q;
  assign out_valid_o  = valid_q;
  assign out_last_o   = last_q;
  assign out_index_o  = res_q.index;
  assign out_score_o  = res_q.score;

endmodule

[tb/tksel_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for top_k_score_selector_core: tracks the held ranking, predicts flush beats
// and compares every result beat field by field. Depends on tksel_pkg.
module tksel_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_i,
  input  logic                         req_type_i,
  input  logic [tksel_pkg::ScoreW-1:0] cand_score_i,
  input  logic [tksel_pkg::IdxW-1:0]   cand_index_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [tksel_pkg::LimW-1:0]   cfg_result_limit_i,
  input  logic                         out_strobe_i,
  input  logic                         out_valid_i,
  input  logic [tksel_pkg::IdxW-1:0]   out_index_i,
  input  logic [tksel_pkg::ScoreW-1:0] out_score_i,
  input  logic                         out_last_i,
  output int                           err_cnt_o,
  output int                           pending_o
);
  import tksel_pkg::*;

  typedef struct packed {
    logic              valid;
    logic [IdxW-1:0]   index;
    logic [ScoreW-1:0] score;
    logic              last;
  } beat_t;

  entry_t            held [CapacityK];
  int                held_cnt;
  logic [LimW-1:0]   limit_q;
  beat_t             flush_beats [$];
  beat_t             want;

  // higher score first, equal scores by lower index
  function automatic logic outranks(entry_t a, entry_t b);
    return (a.score > b.score) || ((a.score == b.score) && (a.index < b.index));
  endfunction

  function automatic int keep_limit();
    if (limit_q == '0 || limit_q > CapacityK) return int'(CapacityK);
    return int'(limit_q);
  endfunction

  task automatic place_entry(input entry_t e);
    int pos;
    pos = held_cnt;
    if (held_cnt < int'(CapacityK)) begin
      // shift lower-ranked entries right behind the insertion point
      while (pos > 0 && outranks(e, held[pos-1])) begin
        held[pos] = held[pos-1];
        pos--;
      end
      held[pos] = e;
      held_cnt++;
    end
  endtask

  task automatic take_offer(input entry_t e);
    if (e.score != '0) begin
      if (held_cnt < keep_limit()) begin
        place_entry(e);
      end else if (held_cnt > 0 && e.score > held[held_cnt-1].score) begin
        // drop the entry ranked last, then rank the newcomer in
        held_cnt--;
        place_entry(e);
      end
    end
  endtask

  task automatic predict_flush();
    beat_t b;
    if (held_cnt == 0) begin
      b = '{valid: 1'b0, index: '0, score: '0, last: 1'b1};
      flush_beats.push_back(b);
    end else begin
      for (int k = 0; k < held_cnt; k++) begin
        b.valid = 1'b1;
        b.index = held[k].index;
        b.score = held[k].score;
        b.last  = (k == held_cnt - 1);
        flush_beats.push_back(b);
      end
      held_cnt = 0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt = 0;
      limit_q  = '0;
      flush_beats.delete();
      pending_o = 0;
      err_cnt_o = 0;
    end else begin
      if (out_strobe_i) begin
        if (flush_beats.size() == 0) begin
          $error("result beat with nothing expected: valid=%0b index=%0h score=%0h last=%0b",
                 out_valid_i, out_index_i, out_score_i, out_last_i);
          err_cnt_o++;
        end else begin
          want = flush_beats.pop_front();
          if (out_valid_i !== want.valid) begin
            $error("out_valid: expected %0b, got %0b", want.valid, out_valid_i);
            err_cnt_o++;
          end
          if (out_index_i !== want.index) begin
            $error("out_index: expected %0h, got %0h", want.index, out_index_i);
            err_cnt_o++;
          end
          if (out_score_i !== want.score) begin
            $error("out_score: expected %0h, got %0h", want.score, out_score_i);
            err_cnt_o++;
          end
          if (out_last_i !== want.last) begin
            $error("out_last: expected %0b, got %0b", want.last, out_last_i);
            err_cnt_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) limit_q = cfg_result_limit_i;
      if (start_i && !busy_i) begin
        if (req_type_i == REQ_FLUSH) predict_flush();
        else take_offer('{score: cand_score_i, index: cand_index_i});
      end
      pending_o = flush_beats.size();
    end
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Top testbench for top_k_score_selector_core: drives offers, flushes and limit writes.
// Depends on tksel_pkg, top_k_score_selector_core and tksel_checker.
module tb;
  import tksel_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int ItemTarget = 430;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic              req_type;
  logic [ScoreW-1:0] cand_score;
  logic [IdxW-1:0]   cand_index;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [LimW-1:0]   cfg_limit;
  logic              out_strobe;
  logic              out_valid;
  logic [IdxW-1:0]   out_index;
  logic [ScoreW-1:0] out_score;
  logic              out_last;
  int                err_cnt;
  int                pending;

  int                n_sent;
  bit                burst;
  int                phase;
  int                span;
  logic [LimW-1:0]   fixed_limits [5] = '{7'd0, 7'd1, 7'd16, 7'd17, 7'd64};

  top_k_score_selector_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .req_type_i         (req_type),
    .cand_score_i       (cand_score),
    .cand_index_i       (cand_index),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_result_limit_i (cfg_limit),
    .out_strobe_o       (out_strobe),
    .out_valid_o        (out_valid),
    .out_index_o        (out_index),
    .out_score_o        (out_score),
    .out_last_o         (out_last)
  );

  tksel_checker chk (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start),
    .busy_i             (busy),
    .req_type_i         (req_type),
    .cand_score_i       (cand_score),
    .cand_index_i       (cand_index),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_i        (cfg_ready),
    .cfg_result_limit_i (cfg_limit),
    .out_strobe_i       (out_strobe),
    .out_valid_i        (out_valid),
    .out_index_i        (out_index),
    .out_score_i        (out_score),
    .out_last_i         (out_last),
    .err_cnt_o          (err_cnt),
    .pending_o          (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("DONE: errors detected");
    $finish;
  end

  // narrow scores in 40% of picks so ties are common, zeros in 10%, the rest full range
  function automatic logic [ScoreW-1:0] pick_score();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r < 5) return ScoreW'($urandom_range(1, 8));
    return $urandom();
  endfunction

  function automatic logic [IdxW-1:0] pick_index();
    if ($urandom_range(0, 1) == 0) return IdxW'($urandom_range(0, 15));
    return $urandom();
  endfunction

  // entered and left at a falling edge; start stays high after the beat
  task automatic issue(input logic req, input logic [ScoreW-1:0] s, input logic [IdxW-1:0] idx);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start      = 1'b1;
    req_type   = req;
    cand_score = s;
    cand_index = idx;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    n_sent++;
  endtask

  // hold off until every expected beat is back and the block is idle
  task automatic settle(input int tail);
    start = 1'b0;
    while (pending != 0 || busy) @(negedge clk_i);
    repeat (tail) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [LimW-1:0] lim);
    settle(4);
    cfg_valid = 1'b1;
    cfg_limit = lim;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  initial begin
    rst_ni     = 1'b0;
    start      = 1'b0;
    req_type   = REQ_OFFER;
    cand_score = '0;
    cand_index = '0;
    cfg_valid  = 1'b0;
    cfg_limit  = '0;
    n_sent     = 0;
    burst      = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // empty store, zero score, extremes and an equal-score pair at capacity limit
    issue(REQ_FLUSH, '1, '1);
    issue(REQ_OFFER, '0, 32'd9);
    issue(REQ_OFFER, '1, '0);
    issue(REQ_OFFER, '1, '1);
    issue(REQ_OFFER, 32'd1, 32'd5);
    issue(REQ_OFFER, 32'd1, 32'd3);
    issue(REQ_FLUSH, '0, '0);

    // full store of two: equal score dropped, lower dropped, last-ranked replaced
    write_limit(7'd2);
    burst = 1'b1;
    issue(REQ_OFFER, 32'd10, 32'd1);
    issue(REQ_OFFER, 32'd10, 32'd2);
    issue(REQ_OFFER, 32'd10, 32'd3);
    issue(REQ_OFFER, 32'd5, 32'd4);
    issue(REQ_OFFER, 32'd20, 32'd7);
    issue(REQ_FLUSH, '0, '0);
    burst = 1'b0;

    // lower the limit below what is held: nothing is discarded
    write_limit(7'd0);
    issue(REQ_OFFER, 32'd30, 32'd11);
    issue(REQ_OFFER, 32'd40, 32'd12);
    issue(REQ_OFFER, 32'd50, 32'd13);
    write_limit(7'd1);
    issue(REQ_OFFER, 32'd45, 32'd14);
    issue(REQ_OFFER, 32'd2, 32'd15);
    issue(REQ_FLUSH, '0, '0);

    phase = 0;
    while (n_sent < ItemTarget) begin
      write_limit(phase < 5 ? fixed_limits[phase] : LimW'($urandom_range(0, 64)));
      burst = ($urandom_range(0, 3) == 0);
      span  = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 12);
      repeat (span) begin
        if ($urandom_range(0, 11) == 0) issue(REQ_FLUSH, $urandom(), $urandom());
        else issue(REQ_OFFER, pick_score(), pick_index());
      end
      issue(REQ_FLUSH, $urandom(), $urandom());
      phase++;
    end

    settle(10);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
